/* hw/rtl/ffd_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed frame deframer package
// Frame geometry, register indexes and the control bundle that the
// sequencer hands to the window cell chain.
// ----------------------------------------------------------------------------
package ffd_pkg;

   // Frame layout: one header byte, the payload, one tail byte.
   localparam int PAYLOAD_BYTES = 53;
   localparam int FRAME_BYTES   = PAYLOAD_BYTES + 2;

   // The fill count must hold every value from zero to a full frame.
   localparam int FILL_W = $clog2(FRAME_BYTES + 1);

   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL   = CSR_IDX_W'(1);

   // Reset values of the marker registers.
   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
   localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'hBB;

   // Commands from the sequencer to the window cells.
   typedef struct packed {
      logic              load_en;
      logic              shift_en;
      logic [FILL_W-1:0] wr_pos;
   } ctrl_type;

endpackage

/* hw/rtl/ffd_cell.sv */
// ----------------------------------------------------------------------------
// Window cell
// Holds one byte of the frame window. It either loads a new request byte,
// takes the byte of its right-hand neighbor when the window shifts, or holds.
// ----------------------------------------------------------------------------
module ffd_cell (
   input  logic                        clock,
   input  logic                        load_en,
   input  logic                        shift_en,
   input  logic [ffd_pkg::BYTE_W-1:0]  load_data,
   input  logic [ffd_pkg::BYTE_W-1:0]  next_data,
   output logic [ffd_pkg::BYTE_W-1:0]  data
);
   import ffd_pkg::*;

   logic [BYTE_W-1:0] data_ff;
   logic [BYTE_W-1:0] data_in;

   // Loading and shifting never happen in the same cycle.
   always_comb begin
      data_in = data_ff;
      if (load_en) begin
         data_in = load_data;
      end else if (shift_en) begin
         data_in = next_data;
      end
   end

   // Payload register, no reset needed.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* hw/rtl/ffd_ctrl.sv */
// ----------------------------------------------------------------------------
// Deframer sequencer
// Tracks the window fill, drops leading bytes that are not the header,
// checks the tail marker on a full window and streams the payload out.
// ----------------------------------------------------------------------------
module ffd_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        rsp_stall,
   input  logic [ffd_pkg::BYTE_W-1:0]  front_byte,
   input  logic [ffd_pkg::BYTE_W-1:0]  tail_pos_byte,
   input  logic [ffd_pkg::BYTE_W-1:0]  header_byte,
   input  logic [ffd_pkg::BYTE_W-1:0]  tail_byte,
   output ffd_pkg::ctrl_type           ctrl,
   output logic                        req_stall,
   output logic                        rsp_valid,
   output logic                        rsp_frame_last
);
   import ffd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_EMIT
   } state_type;

   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_BYTES);
   localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);
   localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(2);

   state_type         state_ff;
   state_type         state_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              shift_en;
   logic              load_en;
   logic [FILL_W-1:0] wr_pos;

   // A full window left behind restarts at the front.
   assign wr_pos = (fill_ff >= FILL_FULL) ? '0 : fill_ff;

   // Next-state logic: one window shift per cycle at most.
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      shift_en = 1'b0;
      load_en  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               load_en  = 1'b1;
               fill_in  = wr_pos + FILL_ONE;
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            priority if (fill_ff == '0) begin
               state_in = ST_IDLE;
            end else if (front_byte != header_byte) begin
               shift_en = 1'b1;
               fill_in  = fill_ff - FILL_ONE;
            end else if (fill_ff < FILL_FULL) begin
               state_in = ST_IDLE;
            end else if (tail_pos_byte != tail_byte) begin
               shift_en = 1'b1;
               fill_in  = fill_ff - FILL_ONE;
            end else begin
               // Valid frame: drop the header and stream the payload.
               shift_en = 1'b1;
               fill_in  = fill_ff - FILL_ONE;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               shift_en = 1'b1;
               if (fill_ff == FILL_LAST) begin
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  fill_in = fill_ff - FILL_ONE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   // Only the tail byte remains behind the final payload byte.
   assign rsp_valid      = (state_ff == ST_EMIT);
   assign rsp_frame_last = (fill_ff == FILL_LAST);
   assign req_stall      = reset || (state_ff != ST_IDLE);

   assign ctrl.load_en  = load_en;
   assign ctrl.shift_en = shift_en;
   assign ctrl.wr_pos   = wr_pos;

endmodule

/* hw/rtl/fixed_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// Fixed frame deframer, top level
// Byte-serial deframer for frames of one header, a fixed payload and a tail.
// ----------------------------------------------------------------------------
// The window is a chain of byte cells that shifts toward the front by one
// byte per cycle, and holds while a response is stalled or the block is idle.
// A request byte is loaded first; the window then drops each leading
// non-header byte, and the header of each full window with a bad tail.
// A valid frame is delivered as 53 responses at one per cycle while
// rsp_stall is low; no request is taken until the last one is out.
// Marker registers may only be written while the block is idle.
// ----------------------------------------------------------------------------
module fixed_frame_deframer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ffd_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ffd_pkg::BYTE_W-1:0]     rsp_payload_byte,
   output logic                           rsp_frame_last,
   input  logic                           csr_wr_en,
   input  logic [ffd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ffd_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import ffd_pkg::*;

   logic [BYTE_W-1:0] header_ff;
   logic [BYTE_W-1:0] tail_ff;
   logic [BYTE_W-1:0] cell_data [FRAME_BYTES];
   ctrl_type          ctrl;

   // Marker registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         tail_ff   <= TAIL_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_HEADER) begin
            header_ff <= csr_wdata[BYTE_W-1:0];
         end else if (csr_index == CSR_TAIL) begin
            tail_ff <= csr_wdata[BYTE_W-1:0];
         end
      end
   end

   // Sequencer.
   ffd_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .rsp_stall      (rsp_stall),
      .front_byte     (cell_data[0]),
      .tail_pos_byte  (cell_data[FRAME_BYTES-1]),
      .header_byte    (header_ff),
      .tail_byte      (tail_ff),
      .ctrl           (ctrl),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_frame_last (rsp_frame_last)
   );

   // Window cell chain; cell zero is the front of the window.
   for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
      logic [BYTE_W-1:0] next_data;
      logic              load_en;

      if (i == FRAME_BYTES - 1) begin : g_end
         assign next_data = '0;
      end else begin : g_mid
         assign next_data = cell_data[i+1];
      end

      assign load_en = ctrl.load_en && (ctrl.wr_pos == FILL_W'(i));

      ffd_cell u_cell (
         .clock     (clock),
         .load_en   (load_en),
         .shift_en  (ctrl.shift_en),
         .load_data (req_rx_byte),
         .next_data (next_data),
         .data      (cell_data[i])
      );
   end

   // The front cell carries the payload byte being delivered.
   assign rsp_payload_byte = cell_data[0];

endmodule

/* hw/rtl/ffd_checker.sv */
// ----------------------------------------------------------------------------
// Fixed frame deframer checker
// Port-level properties of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module ffd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [ffd_pkg::BYTE_W-1:0]     req_rx_byte,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [ffd_pkg::BYTE_W-1:0]     rsp_payload_byte,
   input logic                           rsp_frame_last,
   input logic                           csr_wr_en,
   input logic [ffd_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [ffd_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import ffd_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_rx_byte, csr_wr_en, csr_index, csr_wdata};

   // No request is taken while a frame is being delivered.
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request channel open during frame delivery");

   // An accepted request never yields a response in the very next cycle.
   a_req_then_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("response right after request");

   // Delivery ends right after the final payload byte.
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_frame_last) |=> !rsp_valid)
      else $error("response after final payload byte");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_frame_last)))
      else $error("stalled response changed");

endmodule

bind fixed_frame_deframer_top ffd_checker u_ffd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_rx_byte      (req_rx_byte),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_frame_last   (rsp_frame_last),
   .csr_wr_en        (csr_wr_en),
   .csr_index        (csr_index),
   .csr_wdata        (csr_wdata)
);

/* verif/deframer_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deframer response checker
// Watches the marker registers and both handshake channels, runs its own
// deframing of every accepted request byte, and compares each response
// against the oldest predicted payload byte.
// ----------------------------------------------------------------------------
module deframer_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [ffd_pkg::BYTE_W-1:0]     req_rx_byte,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [ffd_pkg::BYTE_W-1:0]     rsp_payload_byte,
   input  logic                           rsp_frame_last,
   input  logic                           csr_wr_en,
   input  logic [ffd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ffd_pkg::CSR_DAT_W-1:0]  csr_wdata,
   output int                             fail_count,
   output int                             pending
);
   import ffd_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } payload_beat_type;

   // Shadow copies of the marker registers and of the byte window.
   logic [BYTE_W-1:0] header_mark;
   logic [BYTE_W-1:0] tail_mark;
   logic [BYTE_W-1:0] rx_window[$];

   // Payload bytes of validated frames that have not been delivered yet.
   payload_beat_type  frame_payload_q[$];

   int                mismatches = 0;
   int                beats_added;
   int                beats_taken;
   payload_beat_type  oldest_beat;

   assign fail_count = mismatches;

   // Counts a failure; only the first few are described in the log.
   function automatic void log_failure(input string detail);
      mismatches = mismatches + 1;
      if (mismatches <= 10) begin
         $display("[%0t] deframer mismatch: %s", $realtime, detail);
      end
   endfunction

   // Appends one byte, drops leading non-header bytes and the header of any
   // window with a bad tail, until the window is short or a valid frame.
   task automatic deframe_byte(input logic [BYTE_W-1:0] rx, output int added);
      payload_beat_type beat;
      logic             searching;
      int               i;
      added = 0;
      rx_window = {rx_window, rx};
      searching = 1'b1;
      while (searching) begin
         while (rx_window.size() != 0 && rx_window[0] != header_mark) begin
            rx_window.delete(0);
         end
         if (rx_window.size() < FRAME_BYTES) begin
            searching = 1'b0;
         end else if (rx_window[FRAME_BYTES-1] != tail_mark) begin
            rx_window.delete(0);
         end else begin
            for (i = 1; i <= PAYLOAD_BYTES; i++) begin
               beat.data = rx_window[i];
               beat.last = (i == PAYLOAD_BYTES);
               frame_payload_q = {frame_payload_q, beat};
            end
            added = PAYLOAD_BYTES;
            rx_window.delete();
            searching = 1'b0;
         end
      end
   endtask

   // All channel activity is sampled at the rising edge, before the block
   // and the stimulus update their signals.
   always @(posedge clock) begin
      if (reset) begin
         header_mark = HEADER_RESET;
         tail_mark   = TAIL_RESET;
         rx_window.delete();
         frame_payload_q.delete();
         pending <= 0;
      end else begin
         beats_added = 0;
         beats_taken = 0;

         // Writes to indexes other than the two markers have no effect.
         if (csr_wr_en) begin
            case (csr_index)
               CSR_HEADER: header_mark = csr_wdata;
               CSR_TAIL:   tail_mark   = csr_wdata;
               default:    ;
            endcase
         end

         if (req_valid && !req_stall) begin
            deframe_byte(req_rx_byte, beats_added);
         end

         if (rsp_valid && !rsp_stall) begin
            if (frame_payload_q.size() == 0) begin
               log_failure($sformatf("unexpected response byte %02h last %0b",
                                     rsp_payload_byte, rsp_frame_last));
            end else begin
               oldest_beat = frame_payload_q.pop_front();
               beats_taken = 1;
               if (rsp_payload_byte !== oldest_beat.data ||
                   rsp_frame_last !== oldest_beat.last) begin
                  log_failure($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                                        oldest_beat.data, oldest_beat.last,
                                        rsp_payload_byte, rsp_frame_last));
               end
            end
         end

         pending <= pending + beats_added - beats_taken;
      end
   end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fixed frame deframer testbench
// Feeds noise, valid frames and frames with a bad tail under several marker
// settings, with random idling on both sides and one long response hold-off.
// A separate checker predicts every payload byte and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
   import ffd_pkg::*;

   // Register indexes that decode to nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = CSR_IDX_W'(3);

   // Cycles a request can keep the block busy when it produces no response.
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 700;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_rx_byte  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b0;
   logic [BYTE_W-1:0]    rsp_payload_byte;
   logic                 rsp_frame_last;
   logic                 csr_wr_en    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [CSR_DAT_W-1:0] csr_wdata    = '0;

   int                   fail_count;
   int                   pending;

   logic                 no_idle      = 1'b0;
   logic                 hold_trigger = 1'b0;
   logic                 hold_ack     = 1'b0;
   int                   hold_left    = 0;
   logic                 spare_hi     = 1'b0;

   fixed_frame_deframer_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_last   (rsp_frame_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   deframer_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_last   (rsp_frame_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: random stalls, none during quiet stretches, and one long
   // hold-off counted here once the stimulus asks for it.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_ack  <= 1'b0;
      end else if (hold_ack != hold_trigger) begin
         hold_ack  <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < 24);
      end
   end

   // Offers one request byte, with random idle cycles ahead of it, and
   // returns right after the edge at which it is accepted.
   task automatic send_byte(input logic [BYTE_W-1:0] rx);
      while (!no_idle && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops sending and waits until every predicted response is out and any
   // search in the window has had time to finish.
   task automatic drain_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes an unused index first, then both markers, once the block is idle.
   task automatic program_markers(input logic [BYTE_W-1:0] hdr,
                                  input logic [BYTE_W-1:0] tl);
      drain_idle();
      csr_wr_en <= 1'b1;
      csr_index <= spare_hi ? CSR_UNUSED_HI : CSR_UNUSED_LO;
      csr_wdata <= CSR_DAT_W'($urandom_range(255));
      spare_hi  <= !spare_hi;
      @(posedge clock);
      csr_index <= CSR_HEADER;
      csr_wdata <= hdr;
      @(posedge clock);
      csr_index <= CSR_TAIL;
      csr_wdata <= tl;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One marker setting: mostly well-formed frames with random payload (some
   // payload bytes equal to the header), plus frames with a bad tail and
   // bursts of noise.
   task automatic run_phase(input logic [BYTE_W-1:0] hdr,
                            input logic [BYTE_W-1:0] tl,
                            input int                n_items,
                            input bit                long_hold);
      int                pick;
      int                sent;
      int                i;
      logic [BYTE_W-1:0] pb;
      program_markers(hdr, tl);
      if (long_hold) begin
         hold_trigger <= !hold_trigger;
      end
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            repeat ($urandom_range(1, 5)) begin
               send_byte(BYTE_W'($urandom_range(255)));
               sent = sent + 1;
            end
         end else begin
            send_byte(hdr);
            for (i = 0; i < PAYLOAD_BYTES; i++) begin
               pb = ($urandom_range(15) == 0) ? hdr : BYTE_W'($urandom_range(255));
               send_byte(pb);
            end
            // Frames picked below 30 get a tail that differs from the marker.
            send_byte((pick < 30) ? (tl ^ BYTE_W'($urandom_range(1, 255))) : tl);
            sent = sent + FRAME_BYTES;
         end
      end
   endtask

   // Main stimulus and verdict.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extreme noise bytes under the reset markers, then a partial frame.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h55);
      send_byte(8'h80);
      send_byte(HEADER_RESET);
      send_byte(8'h01);
      send_byte(8'hFE);
      send_byte(HEADER_RESET);

      // Header changes while bytes wait in the window.
      program_markers(8'h01, TAIL_RESET);
      send_byte(8'h01);
      send_byte(8'hFF);
      send_byte(8'h00);

      // Extreme markers, a quiet stretch, header equal to tail, random
      // markers under a long hold-off, and back to the reset values.
      run_phase(8'h00, 8'hFF, 40, 1'b0);
      no_idle <= 1'b1;
      run_phase(8'hFF, 8'h00, 40, 1'b0);
      no_idle <= 1'b0;
      run_phase(8'h5A, 8'h5A, 40, 1'b0);
      run_phase(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), 75, 1'b1);
      run_phase(HEADER_RESET, TAIL_RESET, 40, 1'b0);

      drain_idle();
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
